/* rtl/core/ugw_pkg.sv */
// Shared types and constants of the uniform grid ray walker.
// No dependencies; every other file of the block refers to this package by scoped names.
`default_nettype none
package ugw_pkg;

  localparam int FRAC_BITS = 16;
  localparam int MAX_CELLS = 128;

  localparam int T_W     = 32;
  localparam int CNT_W   = 8;
  localparam int WID_W   = 31;
  localparam int COORD_W = 7;
  localparam int LIN_W   = 21;
  localparam int EXT_W   = CNT_W + WID_W;
  localparam int IREM_W  = WID_W + COORD_W;
  localparam int PROD_W  = 2 * T_W;
  localparam int P_W     = T_W + T_W - FRAC_BITS + 1;
  localparam int NUM_W   = P_W + 2;
  localparam int DEN_W   = T_W + 1;
  localparam int CFG_IDX_W = 3;
  localparam int IBIT_W  = 3;

  localparam logic signed [T_W-1:0] T_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [T_W-1:0] T_MIN = 32'sh8000_0000;
  localparam logic [1:0] AXIS_LAST = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CELLS_X  = 3'd0,
    REG_CELLS_Y  = 3'd1,
    REG_CELLS_Z  = 3'd2,
    REG_WIDTH_X  = 3'd3,
    REG_WIDTH_Y  = 3'd4,
    REG_WIDTH_Z  = 3'd5
  } reg_idx_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_STEP, OP_EXT, OP_ZCHK, OP_SAVE_NR, OP_SLAB, OP_PMUL,
    OP_PADD, OP_IDX_INIT, OP_IDX_STEP, OP_IDX_FIN, OP_DELTA, OP_NEXT, OP_ACT, OP_EMIT
  } op_t;

  typedef enum logic [1:0] {
    DS_NR, DS_FR, DS_DELTA, DS_OFF
  } dsel_t;

  typedef struct packed {
    op_t               op;
    dsel_t             dsel;
    logic [1:0]        axis;
    logic [IBIT_W-1:0] ibit;
  } cmd_t;

  typedef struct packed {
    logic in_step;
    logic miss;
    logic dir_zero;
    logic out_free;
  } sts_t;

  typedef struct packed {
    logic                  cmd;
    logic signed [T_W-1:0] origin_x;
    logic signed [T_W-1:0] origin_y;
    logic signed [T_W-1:0] origin_z;
    logic signed [T_W-1:0] dir_x;
    logic signed [T_W-1:0] dir_y;
    logic signed [T_W-1:0] dir_z;
    logic signed [T_W-1:0] ray_t_min;
    logic signed [T_W-1:0] ray_t_max;
    logic                  hit_found;
    logic signed [T_W-1:0] hit_t;
  } in_word_t;

  typedef struct packed {
    logic                  cell_valid;
    logic [LIN_W-1:0]      cell_index;
    logic [COORD_W-1:0]    cell_x;
    logic [COORD_W-1:0]    cell_y;
    logic [COORD_W-1:0]    cell_z;
    logic signed [T_W-1:0] t_enter;
    logic                  done_res;
  } out_word_t;

endpackage
`default_nettype wire

/* rtl/core/ugw_if.sv */
// Valid/ready channel interfaces for the ray word and the result word.
// Depends on ugw_pkg for field widths.
`default_nettype none
interface ugw_in_if;
  logic                               valid;
  logic                               ready;
  logic                               cmd;
  logic signed [ugw_pkg::T_W-1:0]     origin_x;
  logic signed [ugw_pkg::T_W-1:0]     origin_y;
  logic signed [ugw_pkg::T_W-1:0]     origin_z;
  logic signed [ugw_pkg::T_W-1:0]     dir_x;
  logic signed [ugw_pkg::T_W-1:0]     dir_y;
  logic signed [ugw_pkg::T_W-1:0]     dir_z;
  logic signed [ugw_pkg::T_W-1:0]     ray_t_min;
  logic signed [ugw_pkg::T_W-1:0]     ray_t_max;
  logic                               hit_found;
  logic signed [ugw_pkg::T_W-1:0]     hit_t;
  modport source (output valid, cmd, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  ray_t_min, ray_t_max, hit_found, hit_t, input ready);
  modport sink (input valid, cmd, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                ray_t_min, ray_t_max, hit_found, hit_t, output ready);
endinterface

interface ugw_out_if;
  logic                               valid;
  logic                               ready;
  logic                               cell_valid;
  logic [ugw_pkg::LIN_W-1:0]          cell_index;
  logic [ugw_pkg::COORD_W-1:0]        cell_x;
  logic [ugw_pkg::COORD_W-1:0]        cell_y;
  logic [ugw_pkg::COORD_W-1:0]        cell_z;
  logic signed [ugw_pkg::T_W-1:0]     t_enter;
  logic                               done_res;
  modport source (output valid, cell_valid, cell_index, cell_x, cell_y, cell_z, t_enter,
                  done_res, input ready);
  modport sink (input valid, cell_valid, cell_index, cell_x, cell_y, cell_z, t_enter,
                done_res, output ready);
endinterface
`default_nettype wire

/* rtl/core/ugw_div.sv */
// Radix-2 restoring divider for saturating fixed-point quotients, one bit per cycle.
// Depends on ugw_pkg.
`default_nettype none
module ugw_div (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  input  wire logic signed [ugw_pkg::NUM_W-1:0]  num,
  input  wire logic signed [ugw_pkg::DEN_W-1:0]  den,
  output logic                                   busy,
  output logic                                   done,
  output logic signed [ugw_pkg::T_W-1:0]         quo
);
  localparam int QB = 33;
  localparam int NN_W = 63;
  localparam logic [ugw_pkg::NUM_W-1:0] CAP =
    ugw_pkg::NUM_W'(64'd1 << (62 - ugw_pkg::FRAC_BITS));

  logic [ugw_pkg::NUM_W-1:0] un_c, un_cap;
  logic [31:0]               ud_c;
  logic [NN_W-1:0]           nn_c;
  logic                      sat_c;
  logic [QB-1:0]             rem_r, n_r, q_r, r2, rem_nxt;
  logic [31:0]               ud_r;
  logic                      neg_r, sat_r, busy_r, done_r, ge;
  logic [5:0]                cnt_r;

  always_comb begin
    un_c   = num[ugw_pkg::NUM_W-1] ? ugw_pkg::NUM_W'(-num) : ugw_pkg::NUM_W'(num);
    un_cap = (un_c > CAP) ? CAP : un_c;
    ud_c   = den[ugw_pkg::DEN_W-1] ? 32'(-den) : 32'(den);
    nn_c   = NN_W'(un_cap) << ugw_pkg::FRAC_BITS;
    sat_c  = 65'(nn_c) >= (65'(ud_c) << QB);
    r2     = {rem_r[QB-2:0], n_r[QB-1]};
    ge     = r2 >= {1'b0, ud_r};
    rem_nxt = ge ? (r2 - {1'b0, ud_r}) : r2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'(QB);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= QB'(nn_c[NN_W-1:QB]);
      n_r   <= nn_c[QB-1:0];
      q_r   <= '0;
      ud_r  <= ud_c;
      neg_r <= num[ugw_pkg::NUM_W-1] != den[ugw_pkg::DEN_W-1];
      sat_r <= sat_c;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      n_r   <= {n_r[QB-2:0], 1'b0};
      q_r   <= {q_r[QB-2:0], ge};
    end
  end

  always_comb begin
    if (!neg_r) begin
      quo = (sat_r || q_r > 33'h0_7FFF_FFFF) ? ugw_pkg::T_MAX : $signed(q_r[31:0]);
    end else begin
      quo = (sat_r || q_r > 33'h0_8000_0000) ? ugw_pkg::T_MIN : $signed(32'(-q_r));
    end
  end

  assign busy = busy_r;
  assign done = done_r;
endmodule
`default_nettype wire

/* rtl/core/ugw_ctrl.sv */
// Sequencer of the walker: ray setup over three axes, index search, step and emit.
// Depends on ugw_pkg; drives the datapath by command words and reads its status.
`default_nettype none
module ugw_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire ugw_pkg::sts_t sts,
  output ugw_pkg::cmd_t      cmd,
  output logic               div_start,
  input  wire logic          div_done
);
  typedef enum logic [13:0] {
    ST_IDLE  = 14'b00000000000001,
    ST_EXT   = 14'b00000000000010,
    ST_ZCHK  = 14'b00000000000100,
    ST_NR    = 14'b00000000001000,
    ST_FR    = 14'b00000000010000,
    ST_PMUL  = 14'b00000000100000,
    ST_PADD  = 14'b00000001000000,
    ST_IDX0  = 14'b00000010000000,
    ST_IDX   = 14'b00000100000000,
    ST_FIN   = 14'b00001000000000,
    ST_DELTA = 14'b00010000000000,
    ST_OFF   = 14'b00100000000000,
    ST_ACT   = 14'b01000000000000,
    ST_EMIT  = 14'b10000000000000
  } state_t;

  localparam logic [ugw_pkg::IBIT_W-1:0] IBIT_TOP = ugw_pkg::IBIT_W'(ugw_pkg::COORD_W - 1);

  state_t                     state_r, state_nxt;
  logic [1:0]                 axis_r, axis_nxt;
  logic [ugw_pkg::IBIT_W-1:0] cnt_r, cnt_nxt;
  logic                       go_r, go_nxt;
  logic                       last;

  assign last = axis_r == ugw_pkg::AXIS_LAST;

  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    cnt_nxt   = cnt_r;
    go_nxt    = 1'b0;
    cmd.op    = ugw_pkg::OP_NONE;
    cmd.dsel  = ugw_pkg::DS_NR;
    cmd.axis  = axis_r;
    cmd.ibit  = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          axis_nxt = 2'd0;
          if (sts.in_step) begin
            cmd.op    = ugw_pkg::OP_STEP;
            state_nxt = ST_EMIT;
          end else begin
            cmd.op    = ugw_pkg::OP_LOAD;
            state_nxt = ST_EXT;
          end
        end
      end
      ST_EXT: begin
        if (sts.miss) begin
          state_nxt = ST_EMIT;
        end else begin
          cmd.op = ugw_pkg::OP_EXT;
          if (sts.dir_zero) begin
            state_nxt = ST_ZCHK;
          end else begin
            state_nxt = ST_NR;
            go_nxt    = 1'b1;
          end
        end
      end
      ST_ZCHK: begin
        cmd.op    = ugw_pkg::OP_ZCHK;
        axis_nxt  = last ? 2'd0 : axis_r + 2'd1;
        state_nxt = last ? ST_PMUL : ST_EXT;
      end
      ST_NR: begin
        cmd.dsel = ugw_pkg::DS_NR;
        if (div_done) begin
          cmd.op    = ugw_pkg::OP_SAVE_NR;
          state_nxt = ST_FR;
          go_nxt    = 1'b1;
        end
      end
      ST_FR: begin
        cmd.dsel = ugw_pkg::DS_FR;
        if (div_done) begin
          cmd.op    = ugw_pkg::OP_SLAB;
          axis_nxt  = last ? 2'd0 : axis_r + 2'd1;
          state_nxt = last ? ST_PMUL : ST_EXT;
        end
      end
      ST_PMUL: begin
        if (sts.miss) begin
          state_nxt = ST_EMIT;
        end else begin
          cmd.op    = ugw_pkg::OP_PMUL;
          state_nxt = ST_PADD;
        end
      end
      ST_PADD: begin
        cmd.op    = ugw_pkg::OP_PADD;
        state_nxt = ST_IDX0;
      end
      ST_IDX0: begin
        cmd.op    = ugw_pkg::OP_IDX_INIT;
        cnt_nxt   = IBIT_TOP;
        state_nxt = ST_IDX;
      end
      ST_IDX: begin
        cmd.op = ugw_pkg::OP_IDX_STEP;
        if (cnt_r == '0) begin
          state_nxt = ST_FIN;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_FIN: begin
        cmd.op = ugw_pkg::OP_IDX_FIN;
        if (sts.dir_zero) begin
          axis_nxt  = last ? 2'd0 : axis_r + 2'd1;
          state_nxt = last ? ST_ACT : ST_PMUL;
        end else begin
          state_nxt = ST_DELTA;
          go_nxt    = 1'b1;
        end
      end
      ST_DELTA: begin
        cmd.dsel = ugw_pkg::DS_DELTA;
        if (div_done) begin
          cmd.op    = ugw_pkg::OP_DELTA;
          state_nxt = ST_OFF;
          go_nxt    = 1'b1;
        end
      end
      ST_OFF: begin
        cmd.dsel = ugw_pkg::DS_OFF;
        if (div_done) begin
          cmd.op    = ugw_pkg::OP_NEXT;
          axis_nxt  = last ? 2'd0 : axis_r + 2'd1;
          state_nxt = last ? ST_ACT : ST_PMUL;
        end
      end
      ST_ACT: begin
        cmd.op    = ugw_pkg::OP_ACT;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.op    = ugw_pkg::OP_EMIT;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      axis_r  <= 2'd0;
      cnt_r   <= '0;
      go_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
      cnt_r   <= cnt_nxt;
      go_r    <= go_nxt;
    end
  end

  assign in_ready  = state_r == ST_IDLE;
  assign div_start = go_r;
endmodule
`default_nettype wire

/* rtl/core/ugw_dp.sv */
// Datapath of the walker: configuration, ray state, slab clip, index search, stepping, result.
// Depends on ugw_pkg; commanded by ugw_ctrl, shares the ugw_div divider.
`default_nettype none
module ugw_dp (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  cfg_we,
  input  wire logic [ugw_pkg::CFG_IDX_W-1:0]         cfg_idx,
  input  wire logic [ugw_pkg::WID_W-1:0]             cfg_wdata,
  input  wire ugw_pkg::in_word_t                     in_word,
  input  wire ugw_pkg::cmd_t                         cmd,
  output ugw_pkg::sts_t                              sts,
  output logic signed [ugw_pkg::NUM_W-1:0]           div_num,
  output logic signed [ugw_pkg::DEN_W-1:0]           div_den,
  input  wire logic signed [ugw_pkg::T_W-1:0]        div_q,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output ugw_pkg::out_word_t                         out_word
);
  localparam int T_W = ugw_pkg::T_W;
  localparam int CW  = ugw_pkg::COORD_W;

  function automatic logic signed [T_W-1:0] sat33(input logic signed [T_W:0] v);
    if (v > (T_W+1)'(ugw_pkg::T_MAX)) begin
      return ugw_pkg::T_MAX;
    end else if (v < (T_W+1)'(ugw_pkg::T_MIN)) begin
      return ugw_pkg::T_MIN;
    end
    return v[T_W-1:0];
  endfunction

  logic [ugw_pkg::CNT_W-1:0]        cells_r [3];
  logic [ugw_pkg::WID_W-1:0]        width_r [3];
  logic [ugw_pkg::CNT_W-1:0]        n_eff   [3];
  logic [ugw_pkg::WID_W-1:0]        w_eff   [3];
  logic signed [T_W-1:0]            org_r   [3];
  logic signed [T_W-1:0]            dir_r   [3];
  logic [CW-1:0]                    coord_r [3];
  logic signed [1:0]                sign_r  [3];
  logic signed [T_W-1:0]            next_r  [3];
  logic signed [T_W-1:0]            delta_r [3];
  logic signed [T_W-1:0]            lo_r, hi_r, nr_r;
  logic                             miss_r, active_r, out_valid_r;
  logic [ugw_pkg::EXT_W-1:0]        ext_r;
  logic signed [ugw_pkg::PROD_W-1:0] prod_r;
  logic signed [ugw_pkg::P_W-1:0]   p_r;
  logic [ugw_pkg::IREM_W-1:0]       irem_r;
  logic [CW-1:0]                    iq_r;
  logic [2*ugw_pkg::CNT_W-2:0]      n01_r;
  ugw_pkg::out_word_t               out_r;

  logic [1:0]                       a_sel, ax;
  logic signed [T_W-1:0]            org_k, dir_k, nx_k;
  logic [ugw_pkg::CNT_W-1:0]        n_k;
  logic [ugw_pkg::WID_W-1:0]        w_k;
  logic [ugw_pkg::EXT_W-1:0]        bw_c;
  logic [ugw_pkg::IREM_W-1:0]       lim_c, istep_c;
  logic signed [T_W-1:0]            near_c, far_c, nlo_c, nhi_c;
  logic [CW-1:0]                    raw_c, fin_c;
  logic [ugw_pkg::CNT_W-1:0]        nm1_c;
  logic signed [CW+1:0]             c_c;
  logic                             hit_exit, pneg, pbig;
  logic [ugw_pkg::LIN_W-1:0]        lin_c;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (cells_r[k] == '0) begin
        n_eff[k] = ugw_pkg::CNT_W'(1);
      end else if (cells_r[k] > ugw_pkg::CNT_W'(ugw_pkg::MAX_CELLS)) begin
        n_eff[k] = ugw_pkg::CNT_W'(ugw_pkg::MAX_CELLS);
      end else begin
        n_eff[k] = cells_r[k];
      end
      w_eff[k] = (width_r[k] == '0) ? ugw_pkg::WID_W'(1) : width_r[k];
    end
  end

  // Least next crossing: x only when strictly least, then y if below z, else z.
  always_comb begin
    if (next_r[0] < next_r[1] && next_r[0] < next_r[2]) begin
      a_sel = 2'd0;
    end else if (next_r[1] < next_r[2]) begin
      a_sel = 2'd1;
    end else begin
      a_sel = 2'd2;
    end
    ax = (cmd.op == ugw_pkg::OP_STEP) ? a_sel : cmd.axis;
  end

  always_comb begin
    org_k = org_r[ax];
    dir_k = dir_r[ax];
    nx_k  = next_r[ax];
    n_k   = n_eff[ax];
    w_k   = w_eff[ax];
    bw_c  = ugw_pkg::EXT_W'(dir_k < 0 ? {1'b0, coord_r[ax]} : {1'b0, coord_r[ax]} + 8'd1)
            * ugw_pkg::EXT_W'(w_k);
    lim_c   = ugw_pkg::IREM_W'(w_k) << CW;
    istep_c = ugw_pkg::IREM_W'(w_k) << cmd.ibit;
    near_c  = (dir_k < 0) ? div_q : nr_r;
    far_c   = (dir_k < 0) ? nr_r : div_q;
    nlo_c   = (near_c > lo_r) ? near_c : lo_r;
    nhi_c   = (far_c < hi_r) ? far_c : hi_r;
    pneg    = p_r[ugw_pkg::P_W-1];
    pbig    = !pneg && (p_r >= $signed(ugw_pkg::P_W'(lim_c)));
    raw_c   = pneg ? '0 : (pbig ? {CW{1'b1}} : iq_r);
    nm1_c   = n_k - 1'b1;
    fin_c   = ({1'b0, raw_c} > nm1_c) ? nm1_c[CW-1:0] : raw_c;
    c_c     = $signed({2'b00, coord_r[ax]}) + (CW+2)'(sign_r[ax]);
    hit_exit = in_word.hit_found && (in_word.hit_t < nx_k) && (in_word.hit_t < hi_r);
    lin_c   = ugw_pkg::LIN_W'(coord_r[0])
            + ugw_pkg::LIN_W'(n_eff[0] * coord_r[1])
            + ugw_pkg::LIN_W'(n01_r * coord_r[2]);
  end

  always_comb begin
    div_den = ugw_pkg::DEN_W'(dir_k);
    unique case (cmd.dsel)
      ugw_pkg::DS_NR: begin
        div_num = -ugw_pkg::NUM_W'(org_k);
      end
      ugw_pkg::DS_FR: begin
        div_num = $signed(ugw_pkg::NUM_W'(ext_r)) - ugw_pkg::NUM_W'(org_k);
      end
      ugw_pkg::DS_DELTA: begin
        div_num = $signed(ugw_pkg::NUM_W'(w_k));
        div_den = (dir_k < 0) ? -ugw_pkg::DEN_W'(dir_k) : ugw_pkg::DEN_W'(dir_k);
      end
      ugw_pkg::DS_OFF: begin
        div_num = $signed(ugw_pkg::NUM_W'(bw_c)) - ugw_pkg::NUM_W'(p_r);
      end
      default: begin
        div_num = '0;
      end
    endcase
  end

  // Configuration and control flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) begin
        cells_r[k] <= ugw_pkg::CNT_W'(1);
        width_r[k] <= ugw_pkg::WID_W'(1) << ugw_pkg::FRAC_BITS;
      end
      miss_r      <= 1'b0;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          ugw_pkg::REG_CELLS_X: cells_r[0] <= cfg_wdata[ugw_pkg::CNT_W-1:0];
          ugw_pkg::REG_CELLS_Y: cells_r[1] <= cfg_wdata[ugw_pkg::CNT_W-1:0];
          ugw_pkg::REG_CELLS_Z: cells_r[2] <= cfg_wdata[ugw_pkg::CNT_W-1:0];
          ugw_pkg::REG_WIDTH_X: width_r[0] <= cfg_wdata;
          ugw_pkg::REG_WIDTH_Y: width_r[1] <= cfg_wdata;
          ugw_pkg::REG_WIDTH_Z: width_r[2] <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.op == ugw_pkg::OP_EMIT) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (cmd.op)
        ugw_pkg::OP_LOAD: begin
          miss_r   <= 1'b0;
          active_r <= 1'b0;
        end
        ugw_pkg::OP_ZCHK: begin
          if (org_k[T_W-1] || ({8'd0, org_k[T_W-2:0]} > ext_r)) begin
            miss_r <= 1'b1;
          end
        end
        ugw_pkg::OP_SLAB: begin
          if (nlo_c > nhi_c) begin
            miss_r <= 1'b1;
          end
        end
        ugw_pkg::OP_ACT: active_r <= 1'b1;
        ugw_pkg::OP_STEP: begin
          if (active_r) begin
            if (hit_exit || nx_k > hi_r || sign_r[ax] == 2'sd0 || c_c < 0
                || c_c >= $signed({2'b00, n_k})) begin
              active_r <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Ray and walk payload.
  always_ff @(posedge clk) begin
    n01_r <= n_eff[0] * n_eff[1];
    unique case (cmd.op)
      ugw_pkg::OP_LOAD: begin
        org_r[0] <= in_word.origin_x;
        org_r[1] <= in_word.origin_y;
        org_r[2] <= in_word.origin_z;
        dir_r[0] <= in_word.dir_x;
        dir_r[1] <= in_word.dir_y;
        dir_r[2] <= in_word.dir_z;
        lo_r     <= in_word.ray_t_min;
        hi_r     <= in_word.ray_t_max;
      end
      ugw_pkg::OP_EXT:     ext_r <= ugw_pkg::EXT_W'(n_k) * ugw_pkg::EXT_W'(w_k);
      ugw_pkg::OP_SAVE_NR: nr_r <= div_q;
      ugw_pkg::OP_SLAB: begin
        lo_r <= nlo_c;
        hi_r <= nhi_c;
      end
      ugw_pkg::OP_PMUL: prod_r <= ugw_pkg::PROD_W'(lo_r) * ugw_pkg::PROD_W'(dir_k);
      ugw_pkg::OP_PADD: begin
        p_r <= ugw_pkg::P_W'(org_k) + ugw_pkg::P_W'(prod_r >>> ugw_pkg::FRAC_BITS);
      end
      ugw_pkg::OP_IDX_INIT: begin
        irem_r <= p_r[ugw_pkg::IREM_W-1:0];
        iq_r   <= '0;
      end
      ugw_pkg::OP_IDX_STEP: begin
        if (irem_r >= istep_c) begin
          irem_r         <= irem_r - istep_c;
          iq_r[cmd.ibit] <= 1'b1;
        end
      end
      ugw_pkg::OP_IDX_FIN: begin
        coord_r[ax] <= fin_c;
        if (dir_k == 0) begin
          sign_r[ax]  <= 2'sd0;
          delta_r[ax] <= '0;
          next_r[ax]  <= ugw_pkg::T_MAX;
        end
      end
      ugw_pkg::OP_DELTA: delta_r[ax] <= div_q;
      ugw_pkg::OP_NEXT: begin
        next_r[ax] <= sat33((T_W+1)'(lo_r) + (T_W+1)'(div_q));
        sign_r[ax] <= (dir_k < 0) ? -2'sd1 : 2'sd1;
      end
      ugw_pkg::OP_STEP: begin
        if (active_r && !hit_exit) begin
          lo_r <= nx_k;
          if (!(nx_k > hi_r || sign_r[ax] == 2'sd0 || c_c < 0
                || c_c >= $signed({2'b00, n_k}))) begin
            coord_r[ax] <= c_c[CW-1:0];
            next_r[ax]  <= sat33((T_W+1)'(nx_k) + (T_W+1)'(delta_r[ax]));
          end
        end
      end
      ugw_pkg::OP_EMIT: begin
        if (active_r) begin
          out_r.cell_valid <= 1'b1;
          out_r.cell_index <= lin_c;
          out_r.cell_x     <= coord_r[0];
          out_r.cell_y     <= coord_r[1];
          out_r.cell_z     <= coord_r[2];
          out_r.t_enter    <= lo_r;
          out_r.done_res   <= 1'b0;
        end else begin
          out_r.cell_valid <= 1'b0;
          out_r.cell_index <= '0;
          out_r.cell_x     <= '0;
          out_r.cell_y     <= '0;
          out_r.cell_z     <= '0;
          out_r.t_enter    <= '0;
          out_r.done_res   <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    sts.in_step  = in_word.cmd;
    sts.miss     = miss_r;
    sts.dir_zero = dir_k == 0;
    sts.out_free = !out_valid_r || out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;
endmodule
`default_nettype wire

/* rtl/core/uniform_grid_ray_voxel_walker_core.sv */
// Uniform grid ray walker, top level: controller, datapath and a shared serial divider.
// Step word: stepped in its accept cycle; its result is registered once the result register is free.
// Start word: its setup works out up to twelve quotients, one after another, in the bit-serial divider.
// Reset (rst_n low, synchronous) ends any walk, empties the result register and restores
// cell counts of 1 and voxel widths of 1.0.
`default_nettype none
module uniform_grid_ray_voxel_walker_core (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [ugw_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  wire logic [ugw_pkg::WID_W-1:0]         cfg_wdata,
  ugw_in_if.sink                                 in_ch,
  ugw_out_if.source                              out_ch
);
  ugw_pkg::cmd_t                      cmd;
  ugw_pkg::sts_t                      sts;
  ugw_pkg::in_word_t                  in_word;
  ugw_pkg::out_word_t                 out_word;
  logic signed [ugw_pkg::NUM_W-1:0]   div_num;
  logic signed [ugw_pkg::DEN_W-1:0]   div_den;
  logic signed [ugw_pkg::T_W-1:0]     div_q;
  logic                               div_start, div_busy, div_done;
  logic                               in_ready, out_valid;

  // The input word is only looked at in the accept cycle; the start fields are latched then.
  always_comb begin
    in_word.cmd       = in_ch.cmd;
    in_word.origin_x  = in_ch.origin_x;
    in_word.origin_y  = in_ch.origin_y;
    in_word.origin_z  = in_ch.origin_z;
    in_word.dir_x     = in_ch.dir_x;
    in_word.dir_y     = in_ch.dir_y;
    in_word.dir_z     = in_ch.dir_z;
    in_word.ray_t_min = in_ch.ray_t_min;
    in_word.ray_t_max = in_ch.ray_t_max;
    in_word.hit_found = in_ch.hit_found;
    in_word.hit_t     = in_ch.hit_t;
  end

  ugw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .sts       (sts),
    .cmd       (cmd),
    .div_start (div_start),
    .div_done  (div_done)
  );

  ugw_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_word   (in_word),
    .cmd       (cmd),
    .sts       (sts),
    .div_num   (div_num),
    .div_den   (div_den),
    .div_q     (div_q),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .out_word  (out_word)
  );

  // One quotient bit per cycle; slab clip, delta t and first crossing all share it.
  ugw_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_q)
  );

  // The result register decouples the two channels, so a new word may be taken while
  // the previous result is still waiting.
  assign in_ch.ready       = in_ready;
  assign out_ch.valid      = out_valid;
  assign out_ch.cell_valid = out_word.cell_valid;
  assign out_ch.cell_index = out_word.cell_index;
  assign out_ch.cell_x     = out_word.cell_x;
  assign out_ch.cell_y     = out_word.cell_y;
  assign out_ch.cell_z     = out_word.cell_z;
  assign out_ch.t_enter    = out_word.t_enter;
  assign out_ch.done_res   = out_word.done_res;

  // A new quotient is never requested while one is still being worked out.
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy) else $error("divider started while busy");

  // Every accepted word is worked on before the next one is taken.
  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ready) |=> !in_ready) else $error("word taken while busy");

  // A result is only written into a free result register.
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == ugw_pkg::OP_EMIT) |-> sts.out_free) else $error("result overwritten");

  // A done result reports no voxel.
  a_done_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.done_res) |-> (!out_word.cell_valid && out_word.t_enter == 0))
    else $error("done result carries a voxel");
endmodule
`default_nettype wire

/* tb/tb_uniform_grid_ray_voxel_walker_core.sv */
// Testbench for uniform_grid_ray_voxel_walker_core: drives ray and step words, predicts each
// result word with a behavioral voxel-walk model, and checks every result field by field.
// Depends on ugw_pkg, ugw_in_if / ugw_out_if and the core module.
`timescale 1ns / 1ps
`default_nettype none
module tb_uniform_grid_ray_voxel_walker_core;

  // Register index past the end of the register list; the block must ignore it.
  localparam logic [ugw_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd6;
  localparam logic [ugw_pkg::CFG_IDX_W-1:0] REG_UNUSED_TOP = 3'd7;
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP = 1'b1;
  localparam longint Q_ONE = 64'sd65536;
  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [ugw_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [ugw_pkg::WID_W-1:0] cfg_wdata;

  ugw_in_if in_ch ();
  ugw_out_if out_ch ();

  uniform_grid_ray_voxel_walker_core u_top (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit: start words take the longest, and even a run made only of start words with
  // worst-case idling stays far below this limit.
  initial begin
    #(20_000_000);
    $display("FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------------------
  // Walk model. It keeps its own copy of the registers and the traversal state. All t
  // arithmetic is done in 64 bits and saturated back to the signed 32-bit range.
  // ---------------------------------------------------------------------------------------
  logic [ugw_pkg::CNT_W-1:0] grid_cnt [3];
  logic [ugw_pkg::WID_W-1:0] grid_wid [3];
  bit     walking;
  int     vox [3];
  int     step_dir [3];
  longint next_t [3];
  longint delta_t [3];
  longint span_lo, span_hi;

  ugw_pkg::out_word_t expected_cells [$];
  int  error_count;
  int  words_sent;

  function automatic void model_reset();
    for (int a = 0; a < 3; a++) begin
      grid_cnt[a] = 8'd1;
      grid_wid[a] = 31'd65536;
      vox[a] = 0; step_dir[a] = 0; next_t[a] = 0; delta_t[a] = 0;
    end
    walking = 1'b0;
    span_lo = 0;
    span_hi = 0;
  endfunction

  function automatic longint eff_cnt(int a);
    longint n;
    n = grid_cnt[a];
    if (n < 1) n = 1;
    if (n > ugw_pkg::MAX_CELLS) n = ugw_pkg::MAX_CELLS;
    return n;
  endfunction

  function automatic longint eff_wid(int a);
    return (grid_wid[a] == 0) ? 64'sd1 : longint'(grid_wid[a]);
  endfunction

  function automatic longint clamp_t(longint v);
    if (v > SAT_HI) return SAT_HI;
    if (v < SAT_LO) return SAT_LO;
    return v;
  endfunction

  // Fixed-point quotient truncated toward zero; the numerator is capped at 2^46 first.
  function automatic longint fx_quot(longint num, longint den);
    bit neg;
    longint unsigned un, ud, q;
    neg = (num < 0) != (den < 0);
    un = (num < 0) ? -num : num;
    ud = (den < 0) ? -den : den;
    if (un > (64'd1 << 46)) un = 64'd1 << 46;
    q = (un << ugw_pkg::FRAC_BITS) / ud;
    if (!neg) return (q > 64'h7FFF_FFFF) ? SAT_HI : longint'(q);
    if (q > 64'h8000_0000) return SAT_LO;
    return -longint'(q);
  endfunction

  // Fixed-point product rounded toward minus infinity.
  function automatic longint fx_prod(longint a, longint b);
    longint p;
    longint unsigned m;
    p = a * b;
    if (p >= 0) return p >>> ugw_pkg::FRAC_BITS;
    m = -p;
    return -longint'((m + 64'd65535) >> ugw_pkg::FRAC_BITS);
  endfunction

  function automatic ugw_pkg::out_word_t done_word();
    ugw_pkg::out_word_t r;
    r = '0;
    r.done_res = 1'b1;
    return r;
  endfunction

  function automatic ugw_pkg::out_word_t cell_word();
    ugw_pkg::out_word_t r;
    longint lin;
    r = '0;
    lin = vox[0] + eff_cnt(0) * vox[1] + eff_cnt(0) * eff_cnt(1) * vox[2];
    r.cell_valid = 1'b1;
    r.cell_index = lin[ugw_pkg::LIN_W-1:0];
    r.cell_x = vox[0][ugw_pkg::COORD_W-1:0];
    r.cell_y = vox[1][ugw_pkg::COORD_W-1:0];
    r.cell_z = vox[2][ugw_pkg::COORD_W-1:0];
    r.t_enter = span_lo[ugw_pkg::T_W-1:0];
    return r;
  endfunction

  function automatic ugw_pkg::out_word_t begin_ray(ugw_pkg::in_word_t w);
    longint org [3], dir [3], pos [3];
    longint lo, hi, ext, tn, tf, tmp, n, wd, idx, mag;
    walking = 1'b0;
    org[0] = w.origin_x; org[1] = w.origin_y; org[2] = w.origin_z;
    dir[0] = w.dir_x;    dir[1] = w.dir_y;    dir[2] = w.dir_z;
    lo = w.ray_t_min;
    hi = w.ray_t_max;
    // Slab test: an axis with no motion only passes when the origin lies inside it.
    for (int a = 0; a < 3; a++) begin
      ext = eff_cnt(a) * eff_wid(a);
      if (dir[a] == 0) begin
        if (org[a] < 0 || org[a] > ext) return done_word();
        continue;
      end
      tn = fx_quot(-org[a], dir[a]);
      tf = fx_quot(ext - org[a], dir[a]);
      if (dir[a] < 0) begin
        tmp = tn; tn = tf; tf = tmp;
      end
      if (tn > lo) lo = tn;
      if (tf < hi) hi = tf;
      if (lo > hi) return done_word();
    end
    for (int a = 0; a < 3; a++) begin
      n = eff_cnt(a);
      wd = eff_wid(a);
      pos[a] = org[a] + fx_prod(lo, dir[a]);
      idx = (pos[a] < 0) ? 0 : pos[a] / wd;
      if (idx >= n) idx = n - 1;
      vox[a] = int'(idx);
      mag = (dir[a] < 0) ? -dir[a] : dir[a];
      if (mag * 1000000 < Q_ONE) begin
        step_dir[a] = 0;
        delta_t[a] = 0;
        next_t[a] = SAT_HI;
      end else if (dir[a] > 0) begin
        step_dir[a] = 1;
        delta_t[a] = fx_quot(wd, dir[a]);
        next_t[a] = clamp_t(lo + fx_quot((idx + 1) * wd - pos[a], dir[a]));
      end else begin
        step_dir[a] = -1;
        delta_t[a] = fx_quot(wd, -dir[a]);
        next_t[a] = clamp_t(lo + fx_quot(idx * wd - pos[a], dir[a]));
      end
    end
    span_lo = lo;
    span_hi = hi;
    walking = 1'b1;
    return cell_word();
  endfunction

  function automatic ugw_pkg::out_word_t advance_walk(ugw_pkg::in_word_t w);
    int a, c;
    longint ht;
    if (!walking) return done_word();
    // Ties: x only when strictly least, then y if below z, else z.
    if (next_t[0] < next_t[1] && next_t[0] < next_t[2]) a = 0;
    else if (next_t[1] < next_t[2]) a = 1;
    else a = 2;
    ht = w.hit_t;
    if (w.hit_found && ht < next_t[a] && ht < span_hi) begin
      walking = 1'b0;
      return done_word();
    end
    span_lo = next_t[a];
    if (span_lo > span_hi) begin
      walking = 1'b0;
      return done_word();
    end
    c = vox[a] + step_dir[a];
    if (step_dir[a] == 0 || c < 0 || c >= eff_cnt(a)) begin
      walking = 1'b0;
      return done_word();
    end
    vox[a] = c;
    next_t[a] = clamp_t(next_t[a] + delta_t[a]);
    return cell_word();
  endfunction

  // ---------------------------------------------------------------------------------------
  // Drivers. Inputs change at the falling edge; handshakes are sampled at the rising edge.
  // ---------------------------------------------------------------------------------------
  bit src_idle_en;
  bit snk_idle_en;
  int sink_hold;

  // Sends one word, with an optional idle burst first, and predicts its result once the
  // word is taken. valid stays high after the handshake until the next call decides.
  task automatic send_word(ugw_pkg::in_word_t w);
    @(negedge clk);
    if (src_idle_en && $urandom_range(0, 4) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_ch.cmd = w.cmd;
    in_ch.origin_x = w.origin_x;
    in_ch.origin_y = w.origin_y;
    in_ch.origin_z = w.origin_z;
    in_ch.dir_x = w.dir_x;
    in_ch.dir_y = w.dir_y;
    in_ch.dir_z = w.dir_z;
    in_ch.ray_t_min = w.ray_t_min;
    in_ch.ray_t_max = w.ray_t_max;
    in_ch.hit_found = w.hit_found;
    in_ch.hit_t = w.hit_t;
    in_ch.valid = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    words_sent++;
    if (w.cmd == CMD_START) expected_cells.push_back(begin_ray(w));
    else expected_cells.push_back(advance_walk(w));
  endtask

  // Drops valid and waits until every predicted result has come back.
  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (expected_cells.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(logic [ugw_pkg::CFG_IDX_W-1:0] idx,
                           logic [ugw_pkg::WID_W-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_wdata = val;
    @(posedge clk);
    case (idx)
      ugw_pkg::REG_CELLS_X: grid_cnt[0] = val[ugw_pkg::CNT_W-1:0];
      ugw_pkg::REG_CELLS_Y: grid_cnt[1] = val[ugw_pkg::CNT_W-1:0];
      ugw_pkg::REG_CELLS_Z: grid_cnt[2] = val[ugw_pkg::CNT_W-1:0];
      ugw_pkg::REG_WIDTH_X: grid_wid[0] = val;
      ugw_pkg::REG_WIDTH_Y: grid_wid[1] = val;
      ugw_pkg::REG_WIDTH_Z: grid_wid[2] = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_grid(logic [ugw_pkg::WID_W-1:0] nx, logic [ugw_pkg::WID_W-1:0] ny,
                          logic [ugw_pkg::WID_W-1:0] nz, logic [ugw_pkg::WID_W-1:0] wx,
                          logic [ugw_pkg::WID_W-1:0] wy, logic [ugw_pkg::WID_W-1:0] wz);
    cfg_write(ugw_pkg::REG_CELLS_X, nx);
    cfg_write(ugw_pkg::REG_CELLS_Y, ny);
    cfg_write(ugw_pkg::REG_CELLS_Z, nz);
    cfg_write(ugw_pkg::REG_WIDTH_X, wx);
    cfg_write(ugw_pkg::REG_WIDTH_Y, wy);
    cfg_write(ugw_pkg::REG_WIDTH_Z, wz);
  endtask

  function automatic ugw_pkg::in_word_t ray_word(int ox, int oy, int oz, int dx, int dy,
                                                 int dz, int tlo, int thi);
    ugw_pkg::in_word_t w;
    w = '0;
    w.cmd = CMD_START;
    w.origin_x = ox; w.origin_y = oy; w.origin_z = oz;
    w.dir_x = dx; w.dir_y = dy; w.dir_z = dz;
    w.ray_t_min = tlo;
    w.ray_t_max = thi;
    return w;
  endfunction

  function automatic ugw_pkg::in_word_t step_word(bit hit, int ht);
    ugw_pkg::in_word_t w;
    w = '0;
    w.cmd = CMD_STEP;
    w.hit_found = hit;
    w.hit_t = ht;
    return w;
  endfunction

  // Fully random word: every field and every bit takes both values over the run.
  function automatic ugw_pkg::in_word_t noise_word();
    ugw_pkg::in_word_t w;
    w.cmd = $urandom_range(0, 1);
    w.origin_x = $urandom; w.origin_y = $urandom; w.origin_z = $urandom;
    w.dir_x = $urandom; w.dir_y = $urandom; w.dir_z = $urandom;
    w.ray_t_min = $urandom; w.ray_t_max = $urandom;
    w.hit_found = $urandom_range(0, 1);
    w.hit_t = $urandom;
    return w;
  endfunction

  // A ray that mostly starts inside or near the box so that the walk goes several cells.
  function automatic ugw_pkg::in_word_t aimed_ray();
    ugw_pkg::in_word_t w;
    longint org [3], dir [3], ext;
    for (int a = 0; a < 3; a++) begin
      ext = eff_cnt(a) * eff_wid(a);
      case ($urandom_range(0, 9))
        0: org[a] = -longint'($urandom_range(1, 32'h0004_0000));
        1: org[a] = ext + $urandom_range(0, 32'h0002_0000);
        default: org[a] = (ext < SAT_HI) ? longint'($urandom) % (ext + 1)
                                         : longint'($urandom & 32'h7FFF_FFFF);
      endcase
      if ($urandom_range(0, 7) == 0) dir[a] = 0;
      else begin
        dir[a] = $urandom_range(1, 32'h0003_0000);
        if ($urandom_range(0, 1)) dir[a] = -dir[a];
      end
    end
    w = ray_word(int'(clamp_t(org[0])), int'(clamp_t(org[1])), int'(clamp_t(org[2])),
                 int'(dir[0]), int'(dir[1]), int'(dir[2]),
                 ($urandom_range(0, 3) == 0) ? -int'($urandom_range(0, 32'h0004_0000)) : 0,
                 ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 32'h0040_0000))
                                             : 32'h7FFF_FFFF);
    return w;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Result side: the sink stalls in random bursts, or for a long count when sink_hold is set.
  // ---------------------------------------------------------------------------------------
  initial begin
    int stall_left;
    stall_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_hold > 0) begin
        out_ch.ready = 1'b0;
        sink_hold--;
      end else if (stall_left > 0) begin
        out_ch.ready = 1'b0;
        stall_left--;
      end else if (snk_idle_en && $urandom_range(0, 4) == 0) begin
        out_ch.ready = 1'b0;
        stall_left = $urandom_range(0, 2);
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  // Every taken result word is compared with the oldest prediction.
  always @(posedge clk) begin
    ugw_pkg::out_word_t exp_w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_cells.size() == 0) begin
        $display("%0t: unexpected result word cell_valid=%0d done=%0d", $time,
                 out_ch.cell_valid, out_ch.done_res);
        error_count++;
      end else begin
        exp_w = expected_cells.pop_front();
        if (out_ch.cell_valid !== exp_w.cell_valid) begin
          $display("%0t: cell_valid exp %0d got %0d", $time, exp_w.cell_valid,
                   out_ch.cell_valid);
          error_count++;
        end
        if (out_ch.cell_index !== exp_w.cell_index) begin
          $display("%0t: cell_index exp %0d got %0d", $time, exp_w.cell_index,
                   out_ch.cell_index);
          error_count++;
        end
        if (out_ch.cell_x !== exp_w.cell_x) begin
          $display("%0t: cell_x exp %0d got %0d", $time, exp_w.cell_x, out_ch.cell_x);
          error_count++;
        end
        if (out_ch.cell_y !== exp_w.cell_y) begin
          $display("%0t: cell_y exp %0d got %0d", $time, exp_w.cell_y, out_ch.cell_y);
          error_count++;
        end
        if (out_ch.cell_z !== exp_w.cell_z) begin
          $display("%0t: cell_z exp %0d got %0d", $time, exp_w.cell_z, out_ch.cell_z);
          error_count++;
        end
        if (out_ch.t_enter !== exp_w.t_enter) begin
          $display("%0t: t_enter exp %h got %h", $time, exp_w.t_enter, out_ch.t_enter);
          error_count++;
        end
        if (out_ch.done_res !== exp_w.done_res) begin
          $display("%0t: done_res exp %0d got %0d", $time, exp_w.done_res,
                   out_ch.done_res);
          error_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------------------

  // Steps with no walk loaded must each answer done; the reset grid is one 1.0 cell.
  task automatic test_idle_steps_and_reset_grid();
    send_word(step_word(1'b0, 0));
    send_word(step_word(1'b1, 32'h8000_0000));
    send_word(ray_word(32'h8000, 32'h8000, 32'h8000, Q_ONE, 0, 0, 0, 32'h7FFF_FFFF));
    send_word(step_word(1'b0, 0));
    drain();
  endtask

  // Slab corner cases on a 4x4x4 grid of 1.0 cells.
  task automatic test_slab_cases();
    set_grid(4, 4, 4, 32'h1_0000, 32'h1_0000, 32'h1_0000);
    // Still axis outside its slab misses; on the slab boundary it passes.
    send_word(ray_word(32'h8000, -1, 32'h8000, Q_ONE, 0, 0, 0, 32'h7FFF_FFFF));
    send_word(ray_word(32'h8000, 32'h4_0000, 32'h8000, Q_ONE, 0, 0, 0, 32'h7FFF_FFFF));
    // Interval empty from the start.
    send_word(ray_word(32'h8000, 32'h8000, 32'h8000, Q_ONE, Q_ONE, 0, 32'h10_0000, 5));
    // Diagonal ray: every crossing ties, so the tie rule picks the axis.
    send_word(ray_word(32'h8000, 32'h8000, 32'h8000, Q_ONE, Q_ONE, Q_ONE, 0,
                       32'h7FFF_FFFF));
    repeat (4) send_word(step_word(1'b0, 0));
    // A hit nearer than the next crossing ends the walk; a far one does not.
    send_word(ray_word(32'h8000, 32'h1_8000, 32'h8000, Q_ONE, -32'h8000, 0, 0,
                       32'h7FFF_FFFF));
    send_word(step_word(1'b1, 32'h7FFF_FFFF));
    send_word(step_word(1'b1, 32'h4000));
    // Extreme field values.
    send_word(ray_word(32'h7FFF_FFFF, 32'h8000_0000, 0, 32'h8000_0000, 32'h7FFF_FFFF,
                       32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF));
    send_word(ray_word(-32'h1_0000, 32'h2_0000, 32'h2_0000, 32'h7FFF_FFFF, 1, -1,
                       32'h8000_0000, 32'h7FFF_FFFF));
    send_word(step_word(1'b0, 0));
    drain();
  endtask

  // Register values out of range, an unused index, and a write while a walk is loaded.
  task automatic test_register_edges();
    set_grid(0, 200, 8'hFF, 0, 32'h7FFF_FFFF, 1);
    cfg_write(REG_UNUSED, 31'h7FFF_FFFF);
    cfg_write(REG_UNUSED_TOP, 0);
    send_word(ray_word(0, 32'h1000_0000, 0, 1, 32'h100, 32'h3, 0, 32'h7FFF_FFFF));
    send_word(step_word(1'b0, 0));
    drain();
    set_grid(8, 8, 8, 32'h1_0000, 32'h1_0000, 32'h1_0000);
    send_word(ray_word(32'h6_8000, 32'h8000, 32'h8000, Q_ONE, 32'h100, 32'h80, 0,
                       32'h7FFF_FFFF));
    send_word(step_word(1'b0, 0));
    drain();
    // The walk is still loaded; shrinking x puts the current cell out of the grid.
    cfg_write(ugw_pkg::REG_CELLS_X, 2);
    send_word(step_word(1'b0, 0));
    drain();
  endtask

  // Mostly well-formed rays followed by a run of steps, mixed with noise words.
  task automatic run_walks(int n_words);
    int goal;
    int r;
    goal = words_sent + n_words;
    while (words_sent < goal) begin
      r = $urandom_range(0, 9);
      if (r == 0) send_word(noise_word());
      else if (r == 1) send_word(step_word($urandom_range(0, 1), $urandom));
      else begin
        send_word(aimed_ray());
        repeat ($urandom_range(1, 14))
          send_word(step_word($urandom_range(0, 15) == 0,
                              ($urandom_range(0, 1)) ? $urandom
                                                     : $urandom_range(0, 32'h8_0000)));
      end
    end
    drain();
  endtask

  // The sink stops for a long time while steps keep coming, so the block backs up.
  task automatic test_backpressure();
    set_grid(128, 128, 128, 32'h8000, 32'h8000, 32'h8000);
    send_word(ray_word(32'h8000, 32'h8000, 32'h8000, 32'h1_0000, 32'hC000, 32'h8000, 0,
                       32'h7FFF_FFFF));
    drain();
    sink_hold = 200;
    repeat (20) send_word(step_word(1'b0, 0));
    drain();
  endtask

  task automatic test_random_grids();
    set_grid(4, 4, 4, 32'h1_0000, 32'h1_0000, 32'h1_0000);
    run_walks(150);
    set_grid(1, 128, 7, 1, 32'h7FFF_FFFF, 32'h3000);
    run_walks(140);
    set_grid(128, 128, 128, 32'h8000, 32'h8000, 32'h8000);
    run_walks(150);
    set_grid(0, 200, 3, 0, 32'h2_0000, 32'h1_0000);
    run_walks(140);
    set_grid($urandom_range(1, 40), $urandom_range(1, 40), $urandom_range(1, 40),
             $urandom_range(32'h1000, 32'h4_0000), $urandom_range(32'h1000, 32'h4_0000),
             $urandom_range(32'h1000, 32'h4_0000));
    run_walks(150);
  endtask

  // Closing stretch with both sides always ready.
  task automatic test_full_rate();
    src_idle_en = 1'b0;
    snk_idle_en = 1'b0;
    set_grid(8, 8, 8, 32'h1_0000, 32'h1_0000, 32'h1_0000);
    run_walks(100);
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = ugw_pkg::REG_CELLS_X;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_START;
    in_ch.origin_x = '0; in_ch.origin_y = '0; in_ch.origin_z = '0;
    in_ch.dir_x = '0; in_ch.dir_y = '0; in_ch.dir_z = '0;
    in_ch.ray_t_min = '0; in_ch.ray_t_max = '0;
    in_ch.hit_found = 1'b0;
    in_ch.hit_t = '0;
    src_idle_en = 1'b1;
    snk_idle_en = 1'b1;
    sink_hold = 0;
    error_count = 0;
    words_sent = 0;
    model_reset();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_idle_steps_and_reset_grid();
    test_slab_cases();
    test_register_edges();
    test_backpressure();
    test_random_grids();
    test_full_rate();

    // drain() already waited for every result; the block is given more time to show any
    // stray word.
    repeat (20) @(posedge clk);
    if (error_count == 0 && expected_cells.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* files.f */
rtl/core/ugw_pkg.sv
rtl/core/ugw_if.sv
rtl/core/ugw_div.sv
rtl/core/ugw_ctrl.sv
rtl/core/ugw_dp.sv
rtl/core/uniform_grid_ray_voxel_walker_core.sv
tb/tb_uniform_grid_ray_voxel_walker_core.sv
